### sv/modular_inner_product_core_defines.svh
// assertion macros for the modular inner product core
// used by the controller and the datapath; no other dependencies
`ifndef MODULAR_INNER_PRODUCT_CORE_DEFINES_SVH
`define MODULAR_INNER_PRODUCT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MIP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mip assertion failed");
`define MIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mip sequence assertion failed");
`else
`define MIP_ASSERT(label, clk, rst, prop)
`define MIP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/mip_pkg.sv
// shared types for the modular inner product core
// used by mip_ctrl, mip_datapath and the top level
package mip_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP    = 2'd1;
  localparam int unsigned SKIP_W = 16;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_RED_A,
    OP_MOV_A,
    OP_RED_B,
    OP_MOV_B,
    OP_DBL,
    OP_ADD_B,
    OP_MOV_P,
    OP_ADD_P,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic contrib;   // item about to load lies past the skip
    logic last;      // item in flight ends a run
    logic out_busy;  // output register full and not taken this cycle
  } status_t;

endpackage

### sv/mip_ctrl.sv
// sequencer for the modular inner product core
// depends on mip_pkg and the assertion header
`include "modular_inner_product_core_defines.svh"
module mip_ctrl #(
  parameter int unsigned MOD_BITS = 60
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  mip_pkg::status_t  status,
  output mip_pkg::cmd_t     cmd
);
  import mip_pkg::*;

  localparam int unsigned CNT_W = $clog2(MOD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_MOV_A, S_RED_B, S_MOV_B, S_DBL, S_ADD,
    S_MOV_P, S_RED_C, S_ADD_P, S_FIN
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic accept;
  logic cnt_end;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cnt_end  = (cnt == CNT_LAST);

  // operation decode
  always_comb begin
    unique case (state)
      S_IDLE:  cmd.op = accept ? OP_LOAD : OP_IDLE;
      S_RED_A: cmd.op = OP_RED_A;
      S_MOV_A: cmd.op = OP_MOV_A;
      S_RED_B: cmd.op = OP_RED_B;
      S_MOV_B: cmd.op = OP_MOV_B;
      S_DBL:   cmd.op = OP_DBL;
      S_ADD:   cmd.op = OP_ADD_B;
      S_MOV_P: cmd.op = OP_MOV_P;
      S_RED_C: cmd.op = OP_RED_A;
      S_ADD_P: cmd.op = OP_ADD_P;
      S_FIN:   cmd.op = (status.last && status.out_busy) ? OP_IDLE : OP_FIN;
      default: cmd.op = OP_IDLE;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) state <= status.contrib ? S_RED_A : S_MOV_P;
        end
        S_RED_A: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= S_MOV_A;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MOV_A: state <= S_RED_B;
        S_RED_B: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= S_MOV_B;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MOV_B: state <= S_DBL;
        S_DBL:   state <= S_ADD;
        S_ADD: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= S_MOV_P;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_DBL;
          end
        end
        S_MOV_P: state <= S_RED_C;
        S_RED_C: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= S_ADD_P;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ADD_P: state <= S_FIN;
        S_FIN: begin
          if (!(status.last && status.out_busy)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MIP_ASSERT_NEXT(a_accept_branch, clk, rst, accept,
    state == S_RED_A || state == S_MOV_P)
  `MIP_ASSERT(a_cnt_idle, clk, rst, !(state == S_IDLE && s_tvalid) || cnt == '0)

endmodule

### sv/mip_datapath.sv
// registers and modular add unit of the modular inner product core
// depends on mip_pkg and the assertion header
`include "modular_inner_product_core_defines.svh"
module mip_datapath #(
  parameter int unsigned MOD_BITS   = 60,
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mip_pkg::cmd_t                 cmd,
  output mip_pkg::status_t              status,
  input  logic                          cfg_we,
  input  logic [mip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_BITS-1:0]           cfg_modulus,
  input  logic [mip_pkg::SKIP_W-1:0]    cfg_skip,
  input  logic [MOD_BITS-1:0]           a_in,
  input  logic [MOD_BITS-1:0]           b_in,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [MOD_BITS-1:0]           dot
);
  import mip_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned CMP_W = (POS_W > SKIP_W) ? POS_W : SKIP_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

  logic [MOD_BITS-1:0] modulus;
  logic [SKIP_W-1:0]   skip_count;
  logic [POS_W-1:0]    position;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] p;
  logic [MOD_BITS-1:0] opa;
  logic [MOD_BITS-1:0] opb;
  logic [MOD_BITS-1:0] xa;
  logic [MOD_BITS-1:0] r;
  logic                last_q;
  logic                contrib_q;

  logic [MOD_BITS-1:0] add_v;
  logic                add_cin;
  logic [MOD_BITS:0]   add_sum;
  logic [MOD_BITS:0]   add_red;
  logic [MOD_BITS-1:0] add_res;
  logic                contrib_now;

  assign contrib_now = (CMP_W'(position) >= CMP_W'(skip_count));

  assign status.contrib  = contrib_now;
  assign status.last     = last_q;
  assign status.out_busy = out_valid && !out_ready;

  // shared modular add: r + v + cin, one conditional subtract of p
  always_comb begin
    add_v   = '0;
    add_cin = 1'b0;
    case (cmd.op)
      OP_RED_A: begin
        add_v   = r;
        add_cin = opa[MOD_BITS-1];
      end
      OP_RED_B: begin
        add_v   = r;
        add_cin = opb[MOD_BITS-1];
      end
      OP_DBL:   add_v = r;
      OP_ADD_B: add_v = opb[MOD_BITS-1] ? xa : '0;
      OP_ADD_P: add_v = contrib_q ? xa : '0;
      default: begin
        add_v   = '0;
        add_cin = 1'b0;
      end
    endcase
    add_sum = {1'b0, r} + {1'b0, add_v} + (MOD_BITS + 1)'(add_cin);
    add_red = (add_sum >= {1'b0, p}) ? add_sum - {1'b0, p} : add_sum;
    add_res = add_red[MOD_BITS-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= MOD_BITS'(2);
      skip_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODULUS) modulus <= cfg_modulus;
      if (cfg_index == REG_SKIP)    skip_count <= cfg_skip;
    end
  end

  // run state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
      p         <= MOD_BITS'(1);
      r         <= '0;
      last_q    <= 1'b0;
      contrib_q <= 1'b0;
    end else begin
      // a new result loaded in this cycle keeps the output full
      if (out_valid && out_ready && !(cmd.op == OP_FIN && last_q)) out_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          opa       <= a_in;
          opb       <= b_in;
          p         <= (modulus == '0) ? MOD_BITS'(1) : modulus;
          r         <= '0;
          last_q    <= last_in;
          contrib_q <= contrib_now;
          if (last_in)                position <= '0;
          else if (position < POS_MAX) position <= position + 1'b1;
        end
        OP_RED_A: begin
          r   <= add_res;
          opa <= opa << 1;
        end
        OP_MOV_A: begin
          xa <= r;
          r  <= '0;
        end
        OP_RED_B: begin
          r   <= add_res;
          opb <= opb << 1;
        end
        OP_MOV_B: begin
          opb <= r;
          r   <= '0;
        end
        OP_DBL: r <= add_res;
        OP_ADD_B: begin
          r   <= add_res;
          opb <= opb << 1;
        end
        OP_MOV_P: begin
          xa  <= r;
          r   <= '0;
          opa <= acc;
        end
        OP_ADD_P: r <= add_res;
        OP_FIN: begin
          if (last_q) begin
            dot       <= r;
            out_valid <= 1'b1;
            acc       <= '0;
          end else begin
            acc <= r;
          end
        end
        default: ;
      endcase
    end
  end

  `MIP_ASSERT(a_r_reduced, clk, rst, r < p)
  `MIP_ASSERT(a_no_overwrite, clk, rst,
    !(cmd.op == OP_FIN && last_q && out_valid && !out_ready))
  `MIP_ASSERT(a_pos_bound, clk, rst, position <= POS_MAX)

endmodule

### sv/modular_inner_product_core.sv
// Modular inner product core: sum of a*b modulo p over a run of pairs.
// Input stream: s_tdata carries a_value then b_value, s_tlast ends a run.
// Output stream: m_tdata carries dot_value, one transfer per run.
// Configuration: cfg channel, index 0 modulus (0 acts as 1), index 1 skip
// count; always ready. It must be written only while the core is idle; the
// core itself does not enforce this. Each item is worked bit-serially by
// one shared modular adder: reducing a and b, a double-and-add multiply,
// then reducing and adding to the accumulator; an item inside the
// skip only reduces the accumulator. A new item is taken only after the
// previous is done. A result goes to an output register when its last
// item finishes, so the next item is taken while it waits. If it is still
// not taken when the next last item finishes, the core holds until
// m_tready. Reset clears the run, sets modulus to 2 and skip count to 0.
// Depends on mip_pkg, mip_ctrl and mip_datapath.
module modular_inner_product_core #(
  parameter int unsigned MOD_BITS   = 60,
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // a_value, b_value from bit 0, zero padded to bytes
  input  logic [((2*MOD_BITS+7)/8)*8-1:0]       s_tdata,
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // dot_value from bit 0, zero padded to bytes
  output logic [((MOD_BITS+7)/8)*8-1:0]         m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mip_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [((MOD_BITS > 16) ? MOD_BITS : 16)-1:0] cfg_data
);
  import mip_pkg::*;

  localparam int unsigned OUT_W = ((MOD_BITS + 7) / 8) * 8;

  cmd_t                cmd;
  status_t             status;
  logic [MOD_BITS-1:0] dot;

  assign cfg_ready = 1'b1;
  assign m_tdata   = OUT_W'(dot);

  // sequencer
  mip_ctrl #(.MOD_BITS(MOD_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  mip_datapath #(.MOD_BITS(MOD_BITS), .MAX_LENGTH(MAX_LENGTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_modulus (cfg_data[MOD_BITS-1:0]),
    .cfg_skip    (cfg_data[SKIP_W-1:0]),
    .a_in        (s_tdata[MOD_BITS-1:0]),
    .b_in        (s_tdata[2*MOD_BITS-1:MOD_BITS]),
    .last_in     (s_tlast),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .dot         (dot)
  );

endmodule

### sim/tb_modular_inner_product_core.sv
// testbench for modular_inner_product_core: streams runs of residue pairs and
// checks every dot product against a behavioural modular multiply-accumulate
// depends on mip_pkg and the core rtl only
`timescale 1ns / 1ps

import mip_pkg::*;

// expected dot products and the core state they are derived from
class dot_scoreboard;
  localparam int unsigned VW = 60;
  localparam int unsigned MAX_LEN = 65535;

  logic [VW-1:0]     modulus;
  logic [SKIP_W-1:0] skip_count;
  logic [VW-1:0]     acc;
  int unsigned       position;
  logic [VW-1:0]     pending_dots[$];
  int                errors;

  function new();
    modulus    = VW'(2);
    skip_count = '0;
    acc        = '0;
    position   = 0;
    errors     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] value);
    if (idx == REG_MODULUS) modulus = value;
    else if (idx == REG_SKIP) skip_count = value[SKIP_W-1:0];
  endfunction

  // one accepted pair: multiply-accumulate modulo p, result on last
  function void note_item(logic [VW-1:0] a, logic [VW-1:0] b, logic last);
    logic [127:0] p;
    logic [127:0] ra;
    logic [127:0] rb;
    logic [127:0] sum;
    p   = (modulus == '0) ? 128'd1 : {68'd0, modulus};
    ra  = {68'd0, a} % p;
    rb  = {68'd0, b} % p;
    sum = {68'd0, acc} % p;
    if (position >= skip_count) sum = (sum + (ra * rb) % p) % p;
    if (position < MAX_LEN) position++;
    if (last) begin
      pending_dots.push_back(sum[VW-1:0]);
      acc      = '0;
      position = 0;
    end else begin
      acc = sum[VW-1:0];
    end
  endfunction

  function void check_result(logic [63:0] tdata);
    logic [VW-1:0] want;
    if (pending_dots.size() == 0) begin
      $error("dot_value: unexpected result %0h", tdata[VW-1:0]);
      errors++;
      return;
    end
    want = pending_dots.pop_front();
    if (tdata[VW-1:0] !== want) begin
      $error("dot_value: expected %0h actual %0h", want, tdata[VW-1:0]);
      errors++;
    end
  endfunction
endclass

module tb_modular_inner_product_core;
  localparam int unsigned VW = 60;
  localparam int unsigned SETTLE = 340;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [VW-1:0] ALL_ONES = {VW{1'b1}};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [119:0]  s_tdata = '0;   // a_value, b_value
  logic          s_tlast = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [63:0]   m_tdata;        // dot_value
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VW-1:0] cfg_data = '0;

  dot_scoreboard sb = new();
  int unsigned   burst_left = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   tick = 0;
  int unsigned   ready_mode = 0;

  modular_inner_product_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result checking, receiver stall pattern and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    tick <= tick + 1;
    if (tick % 512 == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one pair transfer, with bursty gaps between transfers
  task automatic send_pair(logic [VW-1:0] a, logic [VW-1:0] b, logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_item(a, b, last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // wait for all results, let a trailing item drain, then write a register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] value);
    s_tvalid <= 1'b0;
    while (sb.pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  function automatic logic [VW-1:0] rand_full();
    return VW'({$urandom, $urandom});
  endfunction

  // operand mostly below p, sometimes an extreme or an unreduced value
  function automatic logic [VW-1:0] rand_operand();
    logic [VW-1:0] p;
    p = (sb.modulus == '0) ? VW'(1) : sb.modulus;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return p - 1'b1;
      2: return ALL_ONES;
      3: return rand_full();
      default: return rand_full() % p;
    endcase
  endfunction

  task automatic random_runs(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      for (int unsigned i = 0; i < len; i++)
        send_pair(rand_operand(), rand_operand(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    logic [VW-1:0] moduli[7];
    logic [VW-1:0] skips[7];
    moduli = '{ALL_ONES, VW'(97), VW'(3), 60'h0FF_FFFF_FFFF_FFC5, '0, VW'(1),
               VW'(60'h0A5A_5A5A_5A5A_5A5B)};
    skips  = '{VW'(0), VW'(1), VW'(3), VW'(0), VW'(2), VW'(65535), VW'(0)};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, extremes, unreduced operands
    send_pair(ALL_ONES, ALL_ONES, 1'b1);
    send_pair(VW'(1), VW'(1), 1'b0);
    send_pair(VW'(1), VW'(3), 1'b1);
    write_reg(REG_MODULUS, ALL_ONES);
    send_pair(ALL_ONES - 1'b1, ALL_ONES - 1'b1, 1'b1);
    send_pair('0, ALL_ONES, 1'b0);
    send_pair(ALL_ONES, ALL_ONES - 1'b1, 1'b0);
    send_pair(60'h555_5555_5555_5555, 60'hAAA_AAAA_AAAA_AAAA, 1'b1);
    // run that ends inside the skip
    write_reg(REG_SKIP, VW'(2));
    send_pair(VW'(5), VW'(7), 1'b1);
    send_pair(VW'(5), VW'(7), 1'b0);
    send_pair(VW'(9), VW'(9), 1'b0);
    send_pair(VW'(11), VW'(13), 1'b1);
    // modulus changed part-way through a run
    write_reg(REG_SKIP, '0);
    send_pair(ALL_ONES - 1'b1, VW'(12345), 1'b0);
    write_reg(REG_MODULUS, VW'(97));
    send_pair(VW'(96), VW'(96), 1'b1);
    // spare indexes are ignored
    write_reg(REG_SPARE_2, VW'(7));
    write_reg(REG_SPARE_3, ALL_ONES);
    send_pair(VW'(200), VW'(3), 1'b1);
    // modulus zero and one
    write_reg(REG_MODULUS, '0);
    send_pair(ALL_ONES, ALL_ONES, 1'b1);
    write_reg(REG_MODULUS, VW'(1));
    send_pair(VW'(3), VW'(4), 1'b0);
    send_pair(ALL_ONES, VW'(1), 1'b1);
    write_reg(REG_SKIP, VW'(65535));
    send_pair(VW'(3), VW'(4), 1'b1);

    // random phases over several settings
    for (int i = 0; i < 7; i++) begin
      write_reg(REG_MODULUS, moduli[i]);
      write_reg(REG_SKIP, skips[i]);
      random_runs(235);
    end

    s_tvalid <= 1'b0;
    while (sb.pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
